FILE: src/akm_pkg.sv
// ----------------------------------------------------------------------------
// akm_pkg
// Shared sizes, command codes and the queue item type of the keyword matcher.
// ----------------------------------------------------------------------------
package akm_pkg;

	localparam int PAT_MAX = 64;
	localparam int PAT_AW  = $clog2(PAT_MAX);
	localparam int LEN_W   = $clog2(PAT_MAX + 1);
	localparam int OFF_W   = $clog2(PAT_MAX + 2);
	localparam int POS_W   = $clog2(2 * PAT_MAX + 3);

	localparam int ALT_MAX = 16;
	localparam int ALT_AW  = $clog2(ALT_MAX);
	localparam int ALT_CW  = $clog2(ALT_MAX + 1);

	localparam int CHAR_W = 16;
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 5;
	localparam int MLEN_W = 7;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] BAR_CODE = 16'h007C;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CONTENT = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_CONTENT = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [CHAR_W-1:0] code;
		logic              is_bar;
		logic              first;
		logic              last;
	} item_t;

endpackage

FILE: src/akm_front.sv
// ----------------------------------------------------------------------------
// akm_front
// Takes input transfers, decodes the function code and pushes commands.
// ----------------------------------------------------------------------------
module akm_front import akm_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              first,
	input  logic              last,
	input  logic              q_full,
	output logic              q_push,
	output item_t             q_item
);

	logic known;

	assign in_stall = q_full;

	always_comb begin
		known        = 1'b1;
		q_item.cmd   = CMD_CLEAR;
		q_item.code  = char_code;
		q_item.is_bar = (char_code == BAR_CODE);
		q_item.first = first;
		q_item.last  = last;
		unique case (func)
			FUNC_CLEAR:   q_item.cmd = CMD_CLEAR;
			FUNC_APPEND:  q_item.cmd = CMD_APPEND;
			FUNC_CONTENT: q_item.cmd = CMD_CONTENT;
			default:      known = 1'b0;
		endcase
	end

	// unused function code is dropped here
	assign q_push = in_valid && !q_full && known;

endmodule

FILE: src/akm_queue.sv
// ----------------------------------------------------------------------------
// akm_queue
// Short command queue between the decode front and the match engine.
// ----------------------------------------------------------------------------
module akm_queue import akm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: src/akm_back.sv
// ----------------------------------------------------------------------------
// akm_back
// Match engine: pattern memory, alternative table and the per-character scan
// over all alternatives, one alternative per cycle, plus the result register.
// ----------------------------------------------------------------------------
module akm_back import akm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [IDX_W-1:0]  alt_index,
	output logic [MLEN_W-1:0] match_len
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t              state_q;
	logic [CHAR_W-1:0]   pat_mem [PAT_MAX];
	logic [LEN_W-1:0]    pat_len_q;
	logic [LEN_W-1:0]    alt_start_q [ALT_MAX];
	logic [ALT_CW-1:0]   alt_total_q;
	logic [ALT_MAX-1:0]  alive_q;
	logic [OFF_W-1:0]    offset_q;
	logic                done_q;
	logic                best_valid_q;
	logic [ALT_AW-1:0]   best_alt_q;
	logic [MLEN_W-1:0]   best_len_q;
	logic [CHAR_W-1:0]   code_q;
	logic                last_q;
	logic [ALT_CW-1:0]   k_q;

	logic                v_s1;
	logic [ALT_AW-1:0]   k_s1;
	logic                in_range_s1;
	logic                end_s1;
	logic [CHAR_W-1:0]   rd0_s1;
	logic [CHAR_W-1:0]   rd1_s1;

	logic                out_valid_q;
	logic                found_q;
	logic [IDX_W-1:0]    alt_index_q;
	logic [MLEN_W-1:0]   match_len_q;

	logic                scan_go;
	logic [POS_W-1:0]    pos;
	logic [POS_W-1:0]    pos1;
	logic [ALT_CW-1:0]   app_total;
	logic                app_full;
	logic                app_open;
	logic                mem_we;
	logic [ALT_MAX-1:0]  init_mask;
	logic [ALT_MAX-1:0]  keep_mask;
	logic [ALT_MAX-1:0]  fin_alive;
	logic                hit;
	logic                complete;
	logic                take;
	logic                emit;
	logic                out_free;
	logic                start;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign scan_go  = (k_q < alt_total_q);
	assign pos      = POS_W'(alt_start_q[k_q[ALT_AW-1:0]]) + POS_W'(offset_q);
	assign pos1     = pos + POS_W'(1);
	assign app_full = (pat_len_q == LEN_W'(PAT_MAX));
	assign app_total = (pat_len_q == '0) ? ALT_CW'(1) : alt_total_q;
	assign app_open = q_item.is_bar && (app_total < ALT_CW'(ALT_MAX));
	assign mem_we   = q_pop && (q_item.cmd == CMD_APPEND) && !app_full;
	assign start    = q_item.first || !done_q;

	always_comb begin
		for (int i = 0; i < ALT_MAX; i++) begin
			init_mask[i] = (ALT_CW'(i) < alt_total_q);
			keep_mask[i] = !best_valid_q || (ALT_AW'(i) < best_alt_q);
		end
	end

	assign fin_alive = alive_q & keep_mask;
	assign emit      = (fin_alive == '0) || last_q;
	assign out_free  = !out_valid_q || !out_stall;

	// compare of one alternative against the current content character
	assign hit      = alive_q[k_s1] && in_range_s1 && (rd0_s1 != BAR_CODE) &&
	                  (rd0_s1 == code_q);
	assign complete = end_s1 || (rd1_s1 == BAR_CODE);
	assign take     = v_s1 && hit && complete && (!best_valid_q || (k_s1 < best_alt_q));

	// pattern memory, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pat_mem[pat_len_q[PAT_AW-1:0]] <= q_item.code;
		end
		rd0_s1 <= pat_mem[pos[PAT_AW-1:0]];
		rd1_s1 <= pat_mem[pos1[PAT_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (pat_len_q == '0) begin
				alt_start_q[0] <= '0;
			end
			if (app_open) begin
				alt_start_q[app_total[ALT_AW-1:0]] <= pat_len_q + LEN_W'(1);
			end
		end
		k_s1        <= k_q[ALT_AW-1:0];
		in_range_s1 <= (pos < POS_W'(pat_len_q));
		end_s1      <= (pos1 >= POS_W'(pat_len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pat_len_q    <= '0;
			alt_total_q  <= '0;
			alive_q      <= '0;
			offset_q     <= '0;
			done_q       <= 1'b1;
			best_valid_q <= 1'b0;
			best_alt_q   <= '0;
			best_len_q   <= '0;
			code_q       <= '0;
			last_q       <= 1'b0;
			k_q          <= '0;
			v_s1         <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN) && scan_go;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						unique case (q_item.cmd)
							CMD_CLEAR: begin
								pat_len_q   <= '0;
								alt_total_q <= '0;
								alive_q     <= '0;
								done_q      <= 1'b1;
							end
							CMD_APPEND: begin
								alive_q <= '0;
								done_q  <= 1'b1;
								if (!app_full) begin
									pat_len_q   <= pat_len_q + LEN_W'(1);
									alt_total_q <= app_total + (app_open ? ALT_CW'(1) : '0);
								end
							end
							CMD_CONTENT: begin
								if (q_item.first) begin
									alive_q      <= init_mask;
									offset_q     <= '0;
									done_q       <= 1'b0;
									best_valid_q <= 1'b0;
									best_alt_q   <= '0;
									best_len_q   <= '0;
								end
								// content outside an attempt is dropped
								if (start) begin
									code_q  <= q_item.code;
									last_q  <= q_item.last;
									k_q     <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						k_q <= k_q + ALT_CW'(1);
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!emit || out_free) begin
						if (offset_q < OFF_W'(PAT_MAX + 1)) begin
							offset_q <= offset_q + OFF_W'(1);
						end
						alive_q <= emit ? '0 : fin_alive;
						done_q  <= emit;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (v_s1) begin
				alive_q[k_s1] <= hit && !complete;
			end
			if (take) begin
				best_valid_q <= 1'b1;
				best_alt_q   <= k_s1;
				best_len_q   <= MLEN_W'(offset_q) + MLEN_W'(1);
			end
		end
	end

	// result register, frees up on the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && emit && out_free) begin
			found_q     <= best_valid_q;
			alt_index_q <= best_valid_q ? IDX_W'(best_alt_q) + IDX_W'(1) : '0;
			match_len_q <= best_valid_q ? best_len_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign alt_index = alt_index_q;
	assign match_len = match_len_q;

endmodule

FILE: src/alternation_keyword_matcher_top.sv
// ----------------------------------------------------------------------------
// alternation_keyword_matcher_top
// The command queue registers each transfer, also while a scan runs; the
// engine takes a clear or append from it while idle and scans one content
// character at a time, reading the N alternatives in turn, N being their number.
// One pattern command per cycle while in_stall is low. A result held by out_stall
// holds the engine, once it has a next result to write, until its transfer.
// Reset (arst_n, async, active low): empty pattern, no attempt running.
// ----------------------------------------------------------------------------
module alternation_keyword_matcher_top import akm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              first,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [IDX_W-1:0]  alt_index,
	output logic [MLEN_W-1:0] match_len
);

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	item_t push_item;
	item_t pop_item;

	akm_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.char_code (char_code),
		.first     (first),
		.last      (last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	akm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	akm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.alt_index (alt_index),
		.match_len (match_len)
	);

endmodule
